// ===== rtl/scpu_pkg.sv =====
// Package with shared constants and types of the stepper command and pulse unit.
`timescale 1ns / 1ps
`default_nettype none
package scpu_pkg;

  // Width of the step target, step counter and digit accumulator.
  localparam int COUNT_BITS = 32;

  // Parser levels.
  localparam logic [1:0] MODE_NORMAL  = 2'd0;
  localparam logic [1:0] MODE_AFTER_E = 2'd1;
  localparam logic [1:0] MODE_AFTER_D = 2'd2;
  localparam logic [1:0] MODE_FIELD   = 2'd3;

  // Command characters.
  localparam logic [7:0] CH_END   = 8'h7C;  // '|'
  localparam logic [7:0] CH_EN    = 8'h45;  // 'E'
  localparam logic [7:0] CH_DIR   = 8'h44;  // 'D'
  localparam logic [7:0] CH_STEP  = 8'h53;  // 'S'
  localparam logic [7:0] CH_ONE   = 8'h31;  // '1'
  localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CH_NINE  = 8'h39;  // '9'

  // One result item.
  typedef struct packed {
    logic step_pulse;
    logic stop_event;
    logic driver_enabled;
    logic direction_level;
    logic command_end;
  } result_t;

endpackage
`default_nettype wire

// ===== rtl/scpu_if.sv =====
// Valid/ready channel interfaces for request and result items.
`timescale 1ns / 1ps
`default_nettype none
interface scpu_req_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] cmd_byte;

  modport source (output valid, output req_type, output cmd_byte, input ready);
  modport sink   (input valid, input req_type, input cmd_byte, output ready);
endinterface

interface scpu_res_if;
  logic valid;
  logic ready;
  logic step_pulse;
  logic stop_event;
  logic driver_enabled;
  logic direction_level;
  logic command_end;

  modport source (output valid, output step_pulse, output stop_event,
                  output driver_enabled, output direction_level,
                  output command_end, input ready);
  modport sink   (input valid, input step_pulse, input stop_event,
                  input driver_enabled, input direction_level,
                  input command_end, output ready);
endinterface
`default_nettype wire

// ===== rtl/scpu_core.sv =====
// Command parser and step counter state with the per-item update logic.
`timescale 1ns / 1ps
`default_nettype none
module scpu_core
  import scpu_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       advance,
  input  wire logic       req_type,
  input  wire logic [7:0] cmd_byte,
  output result_t         result
);

  localparam int WIDE_BITS = COUNT_BITS + 4;

  logic [1:0]            parse_mode, parse_mode_next;
  logic [COUNT_BITS-1:0] digit_accumulator, digit_accumulator_next;
  logic                  digits_seen, digits_seen_next;
  logic                  digits_stopped, digits_stopped_next;
  logic [COUNT_BITS-1:0] step_target, step_target_next;
  logic [COUNT_BITS-1:0] steps_done, steps_done_next;
  logic                  enable_flag, enable_flag_next;
  logic                  direction_flag, direction_flag_next;

  logic                  do_normal;
  logic                  is_digit;
  logic [3:0]            digit_byte;
  logic [WIDE_BITS-1:0]  acc_wide;
  logic                  pulse, stop, cend;

  assign is_digit   = (cmd_byte >= CH_ZERO) && (cmd_byte <= CH_NINE);
  // The low nibble of an ASCII digit is its value.
  assign digit_byte = cmd_byte[3:0];
  // acc * 10 + digit, with four spare bits to detect overflow.
  assign acc_wide = {1'b0, digit_accumulator, 3'b000}
                  + {3'b000, digit_accumulator, 1'b0}
                  + {{(WIDE_BITS-4){1'b0}}, digit_byte};

  always_comb begin
    parse_mode_next        = parse_mode;
    digit_accumulator_next = digit_accumulator;
    digits_seen_next       = digits_seen;
    digits_stopped_next    = digits_stopped;
    step_target_next       = step_target;
    steps_done_next        = steps_done;
    enable_flag_next       = enable_flag;
    direction_flag_next    = direction_flag;
    do_normal = 1'b0;
    pulse     = 1'b0;
    stop      = 1'b0;
    cend      = 1'b0;

    if (req_type) begin
      if (step_target != '0) begin
        if (steps_done != step_target) begin
          steps_done_next = steps_done + 1'b1;
          pulse = 1'b1;
        end else begin
          step_target_next = '0;
          steps_done_next  = '0;
          enable_flag_next = 1'b0;
          stop = 1'b1;
        end
      end
    end else begin
      case (parse_mode)
        MODE_AFTER_E: begin
          enable_flag_next = (cmd_byte == CH_ONE);
          parse_mode_next  = MODE_NORMAL;
          do_normal = 1'b1;
        end
        MODE_AFTER_D: begin
          direction_flag_next = (cmd_byte != CH_ONE);
          parse_mode_next     = MODE_NORMAL;
          do_normal = 1'b1;
        end
        MODE_FIELD: begin
          if (cmd_byte == CH_STEP) begin
            if (digits_seen) begin
              step_target_next = digit_accumulator;
            end
            digit_accumulator_next = '0;
            digits_seen_next       = 1'b0;
            digits_stopped_next    = 1'b0;
            parse_mode_next        = MODE_NORMAL;
          end else if (!digits_stopped && is_digit) begin
            if (acc_wide[WIDE_BITS-1:COUNT_BITS] != '0) begin
              digit_accumulator_next = '1;  // saturate
            end else begin
              digit_accumulator_next = acc_wide[COUNT_BITS-1:0];
            end
            digits_seen_next = 1'b1;
          end else begin
            digits_stopped_next = 1'b1;
          end
        end
        default: begin
          do_normal = 1'b1;
        end
      endcase

      if (do_normal) begin
        if (cmd_byte == CH_EN) begin
          parse_mode_next = MODE_AFTER_E;
        end else if (cmd_byte == CH_DIR) begin
          parse_mode_next = MODE_AFTER_D;
        end else if (cmd_byte == CH_STEP) begin
          parse_mode_next        = MODE_FIELD;
          digit_accumulator_next = '0;
          digits_seen_next       = 1'b0;
          digits_stopped_next    = 1'b0;
        end else if (cmd_byte == CH_END) begin
          cend = 1'b1;
        end
      end
    end

    result.step_pulse      = pulse;
    result.stop_event      = stop;
    result.driver_enabled  = enable_flag_next;
    result.direction_level = direction_flag_next;
    result.command_end     = cend;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_mode        <= MODE_NORMAL;
      digit_accumulator <= '0;
      digits_seen       <= 1'b0;
      digits_stopped    <= 1'b0;
      step_target       <= '0;
      steps_done        <= '0;
      enable_flag       <= 1'b0;
      direction_flag    <= 1'b0;
    end else if (advance) begin
      parse_mode        <= parse_mode_next;
      digit_accumulator <= digit_accumulator_next;
      digits_seen       <= digits_seen_next;
      digits_stopped    <= digits_stopped_next;
      step_target       <= step_target_next;
      steps_done        <= steps_done_next;
      enable_flag       <= enable_flag_next;
      direction_flag    <= direction_flag_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/stepper_command_and_pulse_unit.sv =====
// Top level of the stepper command and pulse unit: item registers and handshakes.
// An accepted item passes through the input register, then the update logic writes its
//   result item into the result register.
// Throughput: one item per cycle while the result side keeps ready high.
// Reset (rst, synchronous, active high) empties both registers and returns the parser
//   to the normal level with counts, target, enable and direction cleared.
// Back-pressure on the result side stalls the input register, then the input.
`timescale 1ns / 1ps
`default_nettype none
module stepper_command_and_pulse_unit
  import scpu_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  scpu_req_if.sink   req_ch,
  scpu_res_if.source res_ch
);

  // Input register stage.
  logic       in_valid;
  logic       in_req_type;
  logic [7:0] in_cmd_byte;

  // Result register stage.
  logic    out_valid;
  result_t out_result;

  result_t core_result;
  logic    advance;

  // The input register moves into the result register whenever that register is
  // empty or is being emptied this cycle; the state updates at the same edge.
  assign advance      = in_valid && (!out_valid || res_ch.ready);
  assign req_ch.ready = !in_valid || advance;

  scpu_core u_core (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .req_type (in_req_type),
    .cmd_byte (in_cmd_byte),
    .result   (core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (req_ch.ready) begin
      in_valid <= req_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_ch.ready && req_ch.valid) begin
      in_req_type <= req_ch.req_type;
      in_cmd_byte <= req_ch.cmd_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (res_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= core_result;
    end
  end

  assign res_ch.valid           = out_valid;
  assign res_ch.step_pulse      = out_result.step_pulse;
  assign res_ch.stop_event      = out_result.stop_event;
  assign res_ch.driver_enabled  = out_result.driver_enabled;
  assign res_ch.direction_level = out_result.direction_level;
  assign res_ch.command_end     = out_result.command_end;

endmodule
`default_nettype wire

// ===== dv/stepper_command_and_pulse_unit_test.sv =====
// Self-checking testbench for the stepper command and pulse unit, with its own axis predictor.
`timescale 1ns / 1ps
module stepper_command_and_pulse_unit_test;
  import scpu_pkg::*;

  // Kinds of request item carried in req_type.
  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  // Run shape. The idle limit is far above the longest stall that a correct run can see
  // (a long result hold plus a long request gap).
  localparam int RANDOM_ITEMS = 800;
  localparam int LONG_HOLD    = 60;
  localparam int IDLE_LIMIT   = 3000;
  localparam int DRAIN_CYCLES = 8;
  localparam int REPORT_LIMIT = 10;
  localparam int PAUSE_AT     = 450;
  localparam int HOLD_AT      = 200;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // One row of the directed table. When pinned is set, the row carries its own result;
  // otherwise the predictor supplies it.
  typedef struct {
    logic       kind;
    logic [7:0] code;
    bit         pinned;
    result_t    want;
  } stim_row_t;

  logic clk;
  logic rst;

  scpu_req_if req_ch();
  scpu_res_if res_ch();

  stepper_command_and_pulse_unit dut (
    .clk    (clk),
    .rst    (rst),
    .req_ch (req_ch),
    .res_ch (res_ch)
  );

  // Predicted state of the axis: parser level, the step field being read, the move and
  // the two driver pins.
  logic [1:0]            parse_level;
  logic [COUNT_BITS-1:0] digit_sum;
  logic                  sum_started;
  logic                  sum_closed;
  logic [COUNT_BITS-1:0] move_target;
  logic [COUNT_BITS-1:0] moved_steps;
  logic                  drive_on;
  logic                  drive_backward;

  // Outputs owed by the block, oldest first, one per accepted request item.
  result_t   axis_outputs_due[$];
  stim_row_t directed_rows[$];

  int faults = 0;
  int items_sent = 0;
  int results_seen = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic clear_axis();
    parse_level    = MODE_NORMAL;
    digit_sum      = '0;
    sum_started    = 1'b0;
    sum_closed     = 1'b0;
    move_target    = '0;
    moved_steps    = '0;
    drive_on       = 1'b0;
    drive_backward = 1'b0;
  endtask

  // A byte seen at the normal command level. Returns 1 for the terminator.
  function automatic logic top_level_byte(input logic [7:0] code);
    if (code == CH_EN) begin
      parse_level = MODE_AFTER_E;
    end else if (code == CH_DIR) begin
      parse_level = MODE_AFTER_D;
    end else if (code == CH_STEP) begin
      parse_level = MODE_FIELD;
      digit_sum   = '0;
      sum_started = 1'b0;
      sum_closed  = 1'b0;
    end else if (code == CH_END) begin
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Applies one request item to the predicted axis and returns the result it causes.
  task automatic advance_axis(input logic kind, input logic [7:0] code, output result_t r);
    logic [COUNT_BITS-1:0] digit;
    logic [COUNT_BITS-1:0] room;
    r = '0;
    if (kind == REQ_TICK) begin
      // A zero target means no move. Otherwise step until the counts meet, then stop.
      // When the target was lowered under the done count, stepping goes on and the
      // count wraps around before it can meet the target.
      if (move_target != '0) begin
        if (moved_steps != move_target) begin
          moved_steps  = moved_steps + 1'b1;
          r.step_pulse = 1'b1;
        end else begin
          move_target  = '0;
          moved_steps  = '0;
          drive_on     = 1'b0;
          r.stop_event = 1'b1;
        end
      end
    end else begin
      case (parse_level)
        MODE_AFTER_E: begin
          // The byte after 'E' sets the enable and is then parsed as a command too.
          drive_on      = (code == CH_ONE);
          parse_level   = MODE_NORMAL;
          r.command_end = top_level_byte(code);
        end
        MODE_AFTER_D: begin
          drive_backward = (code != CH_ONE);
          parse_level    = MODE_NORMAL;
          r.command_end  = top_level_byte(code);
        end
        MODE_FIELD: begin
          // Inside a step field the terminator is only a non-digit. A new target is
          // loaded on the closing 'S' only if leading digits came; the done count stays.
          if (code == CH_STEP) begin
            if (sum_started) begin
              move_target = digit_sum;
            end
            digit_sum   = '0;
            sum_started = 1'b0;
            sum_closed  = 1'b0;
            parse_level = MODE_NORMAL;
          end else if (!sum_closed && code >= CH_ZERO && code <= CH_NINE) begin
            digit = COUNT_BITS'(code - CH_ZERO);
            room  = (COUNT_MAX - digit) / 10;
            // Saturate rather than wrap when another digit would overflow the counter.
            digit_sum   = (digit_sum > room) ? COUNT_MAX : digit_sum * 10 + digit;
            sum_started = 1'b1;
          end else begin
            sum_closed = 1'b1;
          end
        end
        default: begin
          r.command_end = top_level_byte(code);
        end
      endcase
    end
    r.driver_enabled  = drive_on;
    r.direction_level = drive_backward;
  endtask

  // Gap length in cycles: none in steady stretches, else mostly short and now and then long.
  function automatic int pick_gap(input bit steady);
    int roll;
    if (steady) begin
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 55) begin
      return 0;
    end else if (roll < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  // Offers one request item, waits for its handshake and records the result it owes.
  // The valid line is only lowered when a gap comes first, so a back-to-back item never
  // sees valid dropped and raised within one time step.
  task automatic send_item(input logic kind, input logic [7:0] code, input bit pinned,
                           input result_t want);
    int      gap;
    result_t predicted;
    gap = pick_gap(items_sent / 100 % 3 == 2);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= kind;
    req_ch.cmd_byte <= code;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    advance_axis(kind, code, predicted);
    axis_outputs_due.push_back(pinned ? want : predicted);
    items_sent++;
  endtask

  task automatic send_byte(input logic [7:0] code);
    send_item(REQ_BYTE, code, 1'b0, '0);
  endtask

  // Sends the decimal digits of a value, most significant first.
  task automatic send_number(input longint unsigned value);
    logic [7:0] digits[$];
    do begin
      digits.push_front(CH_ZERO + 8'(value % 10));
      value = value / 10;
    end while (value != 0);
    foreach (digits[i]) send_byte(digits[i]);
  endtask

  function automatic void pin_row(input logic kind, input logic [7:0] code, input logic pulse,
                                  input logic stop, input logic en, input logic dir,
                                  input logic cend);
    stim_row_t row;
    row.kind   = kind;
    row.code   = code;
    row.pinned = 1'b1;
    row.want   = '{step_pulse: pulse, stop_event: stop, driver_enabled: en,
                   direction_level: dir, command_end: cend};
    directed_rows.push_back(row);
  endfunction

  function automatic void free_row(input logic kind, input logic [7:0] code);
    stim_row_t row;
    row.kind   = kind;
    row.code   = code;
    row.pinned = 1'b0;
    row.want   = '0;
    directed_rows.push_back(row);
  endfunction

  // Random traffic is mostly well-formed commands and tick bursts with random content.
  // Targets are kept small so that moves complete often; a few fields are empty, carry
  // junk after their digits, saturate, or are left open so that later bytes fall inside.
  task automatic send_random_sequence();
    int kind;
    int count;
    int roll;
    longint unsigned value;
    kind = $urandom_range(0, 99);
    if (kind < 30) begin
      send_byte(CH_STEP);
      if ($urandom_range(0, 9) == 0) begin
        send_byte(CH_ZERO);
      end
      roll = $urandom_range(0, 19);
      if (roll == 0) begin
        value = {$urandom, $urandom};
      end else if (roll < 3) begin
        value = $urandom_range(0, 65535);
      end else begin
        value = $urandom_range(0, 30);
      end
      if ($urandom_range(0, 9) != 0) begin
        send_number(value);
      end
      if ($urandom_range(0, 3) == 0) begin
        send_byte(8'($urandom));
        send_number($urandom_range(0, 99));
      end
      if ($urandom_range(0, 9) != 0) begin
        send_byte(CH_STEP);
      end
    end else if (kind < 65) begin
      count = $urandom_range(1, 30);
      repeat (count) send_item(REQ_TICK, 8'($urandom), 1'b0, '0);
    end else if (kind < 75) begin
      send_byte(CH_EN);
      send_byte($urandom_range(0, 1) ? CH_ONE : 8'($urandom));
    end else if (kind < 85) begin
      send_byte(CH_DIR);
      send_byte($urandom_range(0, 1) ? CH_ONE : 8'($urandom));
    end else if (kind < 90) begin
      send_byte(CH_END);
    end else begin
      count = $urandom_range(1, 3);
      repeat (count) send_item(1'($urandom), 8'($urandom), 1'b0, '0);
    end
  endtask

  // Result side: random holds, one long hold once the pipeline has been running for a
  // while, and a check of every accepted result item against the oldest one owed.
  initial begin : result_side
    int      hold;
    bit      long_hold_done;
    result_t got;
    result_t want;
    hold           = 0;
    long_hold_done = 1'b0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
        got.step_pulse      = res_ch.step_pulse;
        got.stop_event      = res_ch.stop_event;
        got.driver_enabled  = res_ch.driver_enabled;
        got.direction_level = res_ch.direction_level;
        got.command_end     = res_ch.command_end;
        results_seen++;
        if (axis_outputs_due.size() == 0) begin
          faults++;
          if (faults <= REPORT_LIMIT) begin
            $display("result %0d: none owed, got pulse/stop/en/dir/end %b",
                     results_seen, got);
          end
        end else begin
          want = axis_outputs_due.pop_front();
          if (got !== want) begin
            faults++;
            if (faults <= REPORT_LIMIT) begin
              $display("result %0d: pulse/stop/en/dir/end expected %b, got %b",
                       results_seen, want, got);
            end
          end
        end
      end
      // The long hold lets the request side keep offering until the block backs up.
      if (!long_hold_done && results_seen >= HOLD_AT) begin
        hold           = LONG_HOLD;
        long_hold_done = 1'b1;
      end else if (hold == 0) begin
        hold = pick_gap(results_seen / 100 % 3 == 0);
      end
      if (hold > 0) begin
        res_ch.ready <= 1'b0;
        hold--;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  // Ends the run when neither channel has moved an item for too long.
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
          (res_ch.valid === 1'b1 && res_ch.ready === 1'b1)) begin
        idle = 0;
      end else begin
        idle++;
      end
    end
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    int directed_count;
    bit paused;
    paused = 1'b0;
    rst             <= 1'b1;
    req_ch.valid    <= 1'b0;
    req_ch.req_type <= REQ_BYTE;
    req_ch.cmd_byte <= '0;
    clear_axis();

    // Directed part. After reset a tick does nothing, the byte extremes are ignored and the
    // terminator raises command_end. 'D' then 'E' turns backward and opens an enable
    // command, which the terminator then closes as disable while also ending the command.
    pin_row(REQ_TICK, 8'h00,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    pin_row(REQ_BYTE, 8'h00,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    pin_row(REQ_BYTE, 8'hFF,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    pin_row(REQ_BYTE, CH_END,  1'b0, 1'b0, 1'b0, 1'b0, 1'b1);
    free_row(REQ_BYTE, CH_EN);
    pin_row(REQ_BYTE, CH_ONE,  1'b0, 1'b0, 1'b1, 1'b0, 1'b0);
    free_row(REQ_BYTE, CH_DIR);
    pin_row(REQ_BYTE, CH_EN,   1'b0, 1'b0, 1'b1, 1'b1, 1'b0);
    pin_row(REQ_BYTE, CH_END,  1'b0, 1'b0, 1'b0, 1'b1, 1'b1);
    // A ten-digit field overflows the counter and saturates; the terminator inside the
    // field is only a non-digit, so no command_end. The first tick then steps.
    free_row(REQ_BYTE, CH_STEP);
    repeat (10) free_row(REQ_BYTE, CH_NINE);
    pin_row(REQ_BYTE, CH_END,  1'b0, 1'b0, 1'b0, 1'b1, 1'b0);
    free_row(REQ_BYTE, CH_STEP);
    pin_row(REQ_TICK, 8'h00,   1'b1, 1'b0, 1'b0, 1'b1, 1'b0);
    // A target of two loaded mid-move keeps the one step done: one more pulse, then stop.
    free_row(REQ_BYTE, CH_STEP);
    free_row(REQ_BYTE, CH_ZERO + 8'd2);
    free_row(REQ_BYTE, CH_STEP);
    pin_row(REQ_TICK, 8'hFF,   1'b1, 1'b0, 1'b0, 1'b1, 1'b0);
    pin_row(REQ_TICK, 8'h00,   1'b0, 1'b1, 1'b0, 1'b1, 1'b0);
    directed_count = directed_rows.size();

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].kind, directed_rows[i].code, directed_rows[i].pinned,
                directed_rows[i].want);
    end

    while (items_sent < directed_count + RANDOM_ITEMS) begin
      // Once in the run the request side goes quiet until every owed result is back.
      if (!paused && items_sent >= PAUSE_AT) begin
        req_ch.valid <= 1'b0;
        while (axis_outputs_due.size() != 0) @(posedge clk);
        @(posedge clk);
        paused = 1'b1;
      end
      send_random_sequence();
    end
    req_ch.valid <= 1'b0;

    while (axis_outputs_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (faults == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/scpu_pkg.sv
rtl/scpu_if.sv
rtl/scpu_core.sv
rtl/stepper_command_and_pulse_unit.sv
dv/stepper_command_and_pulse_unit_test.sv
